/* sv/ssfp_pkg.sv */
// Shared types, constants and helper functions of the sensor stream frame parser.
// Used by the controller, the datapath, the percentage divider and the top level.
// Depends on nothing else.
`default_nettype none

package ssfp_pkg;

  // Frame header byte.
  localparam logic [7:0] HDR_BYTE = 8'h13;

  // Known packet identifiers.
  localparam logic [7:0] ID_BUMPER   = 8'h07;
  localparam logic [7:0] ID_WALL     = 8'h08;
  localparam logic [7:0] ID_CHARGING = 8'h15;
  localparam logic [7:0] ID_CHARGE   = 8'h19;
  localparam logic [7:0] ID_CAPACITY = 8'h1A;
  localparam logic [7:0] ID_WALL_SIG = 8'h1B;
  localparam logic [7:0] ID_RIGHT    = 8'h29;
  localparam logic [7:0] ID_LEFT     = 8'h2A;

  // Percentage arithmetic.
  localparam int          PROD_W     = 23;
  localparam int          QUOT_W     = 8;
  localparam int          PCT_W      = 7;
  localparam logic [6:0]  PCT_SCALE  = 7'd100;
  localparam logic [7:0]  PCT_MAX    = 8'd100;

  // Stream widths.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 104;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sum_load;
    logic sum_add;
    logic bl_load;
    logic bl_dec;
    logic id_load;
    logic hold_load;
    logic store_one;
    logic store_two;
    logic stage_copy;
    logic commit;
    logic div_start;
  } ssfp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_hdr;
    logic len_zero;
    logic id_ok;
    logic bl_last;
    logic cur_one;
    logic sum_ok;
    logic div_done;
  } ssfp_sts_t;

  // Number of data bytes carried by a packet id; zero for an unknown id.
  function automatic logic [1:0] pkt_size(input logic [7:0] id);
    logic [1:0] s;
    unique case (id)
      ID_BUMPER, ID_WALL, ID_CHARGING: s = 2'd1;
      ID_CHARGE, ID_CAPACITY, ID_WALL_SIG, ID_RIGHT, ID_LEFT: s = 2'd2;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* sv/ssfp_div.sv */
// Bit-serial percentage unit: floor(charge * 100 / capacity), saturated at 100.
// Uses constants from ssfp_pkg; instantiated by the datapath.
// Holds the committed percentage, which stays until the next good frame.
`default_nettype none

module ssfp_div
  import ssfp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [15:0]       chg,
  input  wire logic [15:0]       cap,
  output logic                   done,
  output logic [PCT_W-1:0]       pct
);

  logic              busy_r,  busy_nxt;
  logic [2:0]        bit_r,   bit_nxt;
  logic [PROD_W-1:0] rem_r,   rem_nxt;
  logic [15:0]       cap_r,   cap_nxt;
  logic [QUOT_W-1:0] q_r,     q_nxt;
  logic              done_r,  done_nxt;
  logic [PCT_W-1:0]  pct_r,   pct_nxt;

  logic [PROD_W-1:0] trial;
  logic              ge;
  logic [QUOT_W-1:0] q_new;

  // One quotient bit per cycle, most significant first.
  always_comb begin
    trial = {{(PROD_W-16){1'b0}}, cap_r} << bit_r;
    ge    = (rem_r >= trial);
    q_new = q_r | ({{(QUOT_W-1){1'b0}}, ge} << bit_r);
  end

  always_comb begin
    busy_nxt = busy_r;
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    cap_nxt  = cap_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    pct_nxt  = pct_r;
    if (start) begin
      // The product is registered before the first compare.
      rem_nxt  = PROD_W'({7'd0, chg} * {16'd0, PCT_SCALE});
      cap_nxt  = cap;
      q_nxt    = '0;
      bit_nxt  = 3'd7;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - trial;
      end
      q_nxt = q_new;
      if (bit_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        // Any quotient of 128 or more has its top bit set and saturates too.
        if (cap_r == 16'd0) begin
          pct_nxt = '0;
        end else if (q_new > PCT_MAX) begin
          pct_nxt = PCT_MAX[PCT_W-1:0];
        end else begin
          pct_nxt = q_new[PCT_W-1:0];
        end
      end else begin
        bit_nxt = bit_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      bit_r  <= '0;
      done_r <= 1'b0;
      pct_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      bit_r  <= bit_nxt;
      done_r <= done_nxt;
      pct_r  <= pct_nxt;
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    cap_r <= cap_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign pct  = pct_r;

endmodule

`default_nettype wire

/* sv/ssfp_dp.sv */
// Datapath of the frame parser: checksum, byte count, staged and committed fields.
// Uses ssfp_pkg and instantiates ssfp_div for the charge percentage.
// Driven by ssfp_ctrl through the command struct; reports back through the status struct.
`default_nettype none

module ssfp_dp
  import ssfp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         data_byte,
  input  wire ssfp_cmd_t          cmd,
  output ssfp_sts_t               sts,
  output logic [7:0]              bumper_bits,
  output logic                    wall_seen,
  output logic [7:0]              charge_mode,
  output logic [15:0]             battery_charge,
  output logic [15:0]             battery_capacity,
  output logic [PCT_W-1:0]        charge_percent,
  output logic [15:0]             wall_signal,
  output logic [15:0]             right_speed,
  output logic [15:0]             left_speed
);

  logic [7:0]  sum_r,  sum_nxt;
  logic [7:0]  bl_r,   bl_nxt;
  logic [7:0]  id_r,   id_nxt;
  logic [7:0]  hold_r, hold_nxt;

  // Staged fields of the frame in progress.
  logic [7:0]  sg_bump_r, sg_bump_nxt;
  logic        sg_wall_r, sg_wall_nxt;
  logic [7:0]  sg_chst_r, sg_chst_nxt;
  logic [15:0] sg_chg_r,  sg_chg_nxt;
  logic [15:0] sg_cap_r,  sg_cap_nxt;
  logic [15:0] sg_wpw_r,  sg_wpw_nxt;
  logic [15:0] sg_rgt_r,  sg_rgt_nxt;
  logic [15:0] sg_lft_r,  sg_lft_nxt;

  // Fields of the last valid frame.
  logic [7:0]  cm_bump_r, cm_bump_nxt;
  logic        cm_wall_r, cm_wall_nxt;
  logic [7:0]  cm_chst_r, cm_chst_nxt;
  logic [15:0] cm_chg_r,  cm_chg_nxt;
  logic [15:0] cm_cap_r,  cm_cap_nxt;
  logic [15:0] cm_wpw_r,  cm_wpw_nxt;
  logic [15:0] cm_rgt_r,  cm_rgt_nxt;
  logic [15:0] cm_lft_r,  cm_lft_nxt;

  logic [1:0]  in_size;
  logic [7:0]  bl_m1;
  logic [7:0]  sum_add;
  logic [15:0] word;
  logic        div_done;
  logic [PCT_W-1:0] div_pct;

  // Status decoding of the current byte and counters.
  always_comb begin
    in_size      = pkt_size(data_byte);
    bl_m1        = bl_r - 8'd1;
    sum_add      = sum_r + data_byte;
    word         = {hold_r, data_byte};
    sts.is_hdr   = (data_byte == HDR_BYTE);
    sts.len_zero = (data_byte == 8'd0);
    sts.id_ok    = (in_size != 2'd0) && ({6'd0, in_size} <= bl_m1);
    sts.bl_last  = (bl_r == 8'd1);
    sts.cur_one  = (pkt_size(id_r) == 2'd1);
    sts.sum_ok   = (sum_add == 8'd0);
    sts.div_done = div_done;
  end

  // Parsing counters.
  always_comb begin
    sum_nxt  = sum_r;
    bl_nxt   = bl_r;
    id_nxt   = id_r;
    hold_nxt = hold_r;
    if (cmd.sum_load) begin
      sum_nxt = HDR_BYTE;
    end else if (cmd.sum_add) begin
      sum_nxt = sum_add;
    end
    if (cmd.bl_load) begin
      bl_nxt = data_byte;
    end else if (cmd.bl_dec) begin
      bl_nxt = bl_m1;
    end
    if (cmd.id_load) begin
      id_nxt = data_byte;
    end
    if (cmd.hold_load) begin
      hold_nxt = data_byte;
    end
  end

  // Staging: copied from the committed set at a header, then updated per packet.
  always_comb begin
    sg_bump_nxt = sg_bump_r;
    sg_wall_nxt = sg_wall_r;
    sg_chst_nxt = sg_chst_r;
    sg_chg_nxt  = sg_chg_r;
    sg_cap_nxt  = sg_cap_r;
    sg_wpw_nxt  = sg_wpw_r;
    sg_rgt_nxt  = sg_rgt_r;
    sg_lft_nxt  = sg_lft_r;
    if (cmd.stage_copy) begin
      sg_bump_nxt = cm_bump_r;
      sg_wall_nxt = cm_wall_r;
      sg_chst_nxt = cm_chst_r;
      sg_chg_nxt  = cm_chg_r;
      sg_cap_nxt  = cm_cap_r;
      sg_wpw_nxt  = cm_wpw_r;
      sg_rgt_nxt  = cm_rgt_r;
      sg_lft_nxt  = cm_lft_r;
    end else if (cmd.store_one) begin
      unique case (id_r)
        ID_BUMPER:   sg_bump_nxt = data_byte;
        ID_WALL:     sg_wall_nxt = data_byte[0];
        ID_CHARGING: sg_chst_nxt = data_byte;
        default: ;
      endcase
    end else if (cmd.store_two) begin
      unique case (id_r)
        ID_CHARGE:   sg_chg_nxt = word;
        ID_CAPACITY: sg_cap_nxt = word;
        ID_WALL_SIG: sg_wpw_nxt = word;
        ID_RIGHT:    sg_rgt_nxt = word;
        ID_LEFT:     sg_lft_nxt = word;
        default: ;
      endcase
    end
  end

  // Commit on a good checksum.
  always_comb begin
    cm_bump_nxt = cm_bump_r;
    cm_wall_nxt = cm_wall_r;
    cm_chst_nxt = cm_chst_r;
    cm_chg_nxt  = cm_chg_r;
    cm_cap_nxt  = cm_cap_r;
    cm_wpw_nxt  = cm_wpw_r;
    cm_rgt_nxt  = cm_rgt_r;
    cm_lft_nxt  = cm_lft_r;
    if (cmd.commit) begin
      cm_bump_nxt = sg_bump_r;
      cm_wall_nxt = sg_wall_r;
      cm_chst_nxt = sg_chst_r;
      cm_chg_nxt  = sg_chg_r;
      cm_cap_nxt  = sg_cap_r;
      cm_wpw_nxt  = sg_wpw_r;
      cm_rgt_nxt  = sg_rgt_r;
      cm_lft_nxt  = sg_lft_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      bl_r      <= '0;
      id_r      <= '0;
      hold_r    <= '0;
      cm_bump_r <= '0;
      cm_wall_r <= 1'b0;
      cm_chst_r <= '0;
      cm_chg_r  <= '0;
      cm_cap_r  <= '0;
      cm_wpw_r  <= '0;
      cm_rgt_r  <= '0;
      cm_lft_r  <= '0;
    end else begin
      sum_r     <= sum_nxt;
      bl_r      <= bl_nxt;
      id_r      <= id_nxt;
      hold_r    <= hold_nxt;
      cm_bump_r <= cm_bump_nxt;
      cm_wall_r <= cm_wall_nxt;
      cm_chst_r <= cm_chst_nxt;
      cm_chg_r  <= cm_chg_nxt;
      cm_cap_r  <= cm_cap_nxt;
      cm_wpw_r  <= cm_wpw_nxt;
      cm_rgt_r  <= cm_rgt_nxt;
      cm_lft_r  <= cm_lft_nxt;
    end
  end

  // The staged set is always loaded at a header before use.
  always_ff @(posedge clk) begin
    sg_bump_r <= sg_bump_nxt;
    sg_wall_r <= sg_wall_nxt;
    sg_chst_r <= sg_chst_nxt;
    sg_chg_r  <= sg_chg_nxt;
    sg_cap_r  <= sg_cap_nxt;
    sg_wpw_r  <= sg_wpw_nxt;
    sg_rgt_r  <= sg_rgt_nxt;
    sg_lft_r  <= sg_lft_nxt;
  end

  // The percentage is worked out from the values being committed.
  ssfp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .chg   (sg_chg_r),
    .cap   (sg_cap_r),
    .done  (div_done),
    .pct   (div_pct)
  );

  assign bumper_bits      = cm_bump_r;
  assign wall_seen        = cm_wall_r;
  assign charge_mode      = cm_chst_r;
  assign battery_charge   = cm_chg_r;
  assign battery_capacity = cm_cap_r;
  assign charge_percent   = div_pct;
  assign wall_signal      = cm_wpw_r;
  assign right_speed      = cm_rgt_r;
  assign left_speed       = cm_lft_r;

endmodule

`default_nettype wire

/* sv/ssfp_ctrl.sv */
// Controller of the frame parser: frame state machine and result handshake.
// Uses ssfp_pkg; drives ssfp_dp through the command struct.
// Holds the output valid flag and the frame-good flag of the pending result.
`default_nettype none

module ssfp_ctrl
  import ssfp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output logic           frame_ok,
  input  wire ssfp_sts_t sts,
  output ssfp_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_HEADER,
    S_LENGTH,
    S_ID,
    S_DATA1,
    S_DATA2,
    S_SKIP,
    S_CHK_GOOD,
    S_CHK_BAD,
    S_PCT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   ok_r, ok_nxt;
  logic   is_chk;
  logic   out_busy;
  logic   acc;

  // A checksum byte waits while an earlier result is still untaken.
  always_comb begin
    is_chk    = (state_r == S_CHK_GOOD) || (state_r == S_CHK_BAD);
    out_busy  = out_valid_r && !out_tready;
    in_tready = (state_r != S_PCT) && !(is_chk && out_busy);
    acc       = in_tvalid && in_tready;
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ok_nxt        = ok_r;
    cmd           = '0;
    unique case (state_r)
      S_HEADER: begin
        if (acc && sts.is_hdr) begin
          cmd.sum_load   = 1'b1;
          cmd.stage_copy = 1'b1;
          state_nxt      = S_LENGTH;
        end
      end
      S_LENGTH: begin
        if (acc) begin
          cmd.sum_add = 1'b1;
          cmd.bl_load = 1'b1;
          state_nxt   = sts.len_zero ? S_CHK_GOOD : S_ID;
        end
      end
      S_ID: begin
        if (acc) begin
          cmd.sum_add = 1'b1;
          cmd.bl_dec  = 1'b1;
          cmd.id_load = 1'b1;
          if (sts.id_ok) begin
            state_nxt = S_DATA1;
          end else begin
            state_nxt = sts.bl_last ? S_CHK_BAD : S_SKIP;
          end
        end
      end
      S_DATA1: begin
        if (acc) begin
          cmd.sum_add = 1'b1;
          cmd.bl_dec  = 1'b1;
          if (sts.cur_one) begin
            cmd.store_one = 1'b1;
            state_nxt     = sts.bl_last ? S_CHK_GOOD : S_ID;
          end else begin
            cmd.hold_load = 1'b1;
            state_nxt     = S_DATA2;
          end
        end
      end
      S_DATA2: begin
        if (acc) begin
          cmd.sum_add   = 1'b1;
          cmd.bl_dec    = 1'b1;
          cmd.store_two = 1'b1;
          state_nxt     = sts.bl_last ? S_CHK_GOOD : S_ID;
        end
      end
      S_SKIP: begin
        if (acc) begin
          cmd.sum_add = 1'b1;
          cmd.bl_dec  = 1'b1;
          if (sts.bl_last) begin
            state_nxt = S_CHK_BAD;
          end
        end
      end
      S_CHK_GOOD: begin
        if (acc) begin
          if (sts.sum_ok) begin
            cmd.commit    = 1'b1;
            cmd.div_start = 1'b1;
            state_nxt     = S_PCT;
          end else begin
            out_valid_nxt = 1'b1;
            ok_nxt        = 1'b0;
            state_nxt     = S_HEADER;
          end
        end
      end
      S_CHK_BAD: begin
        if (acc) begin
          out_valid_nxt = 1'b1;
          ok_nxt        = 1'b0;
          state_nxt     = S_HEADER;
        end
      end
      S_PCT: begin
        // The result is shown once the percentage is in place.
        if (sts.div_done) begin
          out_valid_nxt = 1'b1;
          ok_nxt        = 1'b1;
          state_nxt     = S_HEADER;
        end
      end
      default: begin
        state_nxt = S_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_HEADER;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ok_r        <= ok_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign frame_ok   = ok_r;

endmodule

`default_nettype wire

/* sv/sensor_stream_frame_parser.sv */
// Top level of the sensor stream frame parser.
// Uses ssfp_pkg and instantiates ssfp_ctrl and ssfp_dp (which holds ssfp_div).
`default_nettype none

// Takes a sensor stream one byte per item: header 0x13, a length byte counting
// the bytes up to the checksum, packet-id/data groups, then a checksum byte that
// makes the frame's byte sum zero mod 256. Each checksum byte gives one result;
// frame_ok (in out_tuser) tells whether the frame was good, and the other fields
// always show the last good frame (zero before the first). After the checksum byte
// of a good frame the input stalls while the bit-serial divider forms the charge
// percentage, one quotient bit per cycle after a registered multiply. A checksum
// byte is also held off while the previous result is still waiting at the output;
// other bytes are not.

module sensor_stream_frame_parser
  import ssfp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // data_byte [7:0]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // bumper_bits [7:0], wall_seen [8], charge_mode [16:9],
  // battery_charge [32:17], battery_capacity [48:33], charge_percent [55:49],
  // wall_signal [71:56], right_speed [87:72], left_speed [103:88]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // frame_ok [0]
  output logic                       out_tuser
);

  ssfp_cmd_t        cmd;
  ssfp_sts_t        sts;
  logic [7:0]       bumper_bits;
  logic             wall_seen;
  logic [7:0]       charge_mode;
  logic [15:0]      battery_charge;
  logic [15:0]      battery_capacity;
  logic [PCT_W-1:0] charge_percent;
  logic [15:0]      wall_signal;
  logic [15:0]      right_speed;
  logic [15:0]      left_speed;

  ssfp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .frame_ok   (out_tuser),
    .sts        (sts),
    .cmd        (cmd)
  );

  ssfp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .data_byte        (in_tdata),
    .cmd              (cmd),
    .sts              (sts),
    .bumper_bits      (bumper_bits),
    .wall_seen        (wall_seen),
    .charge_mode      (charge_mode),
    .battery_charge   (battery_charge),
    .battery_capacity (battery_capacity),
    .charge_percent   (charge_percent),
    .wall_signal      (wall_signal),
    .right_speed      (right_speed),
    .left_speed       (left_speed)
  );

  // Result fields packed from the lowest bit up.
  assign out_tdata = {left_speed, right_speed, wall_signal, charge_percent,
                      battery_capacity, battery_charge, charge_mode,
                      wall_seen, bumper_bits};

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the sensor stream frame parser.
// Depends on ssfp_pkg for the header byte, the packet ids and the stream widths,
// and on the top level sensor_stream_frame_parser.
`timescale 1ns / 100ps

module tb
  import ssfp_pkg::*;
();

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 600;
  localparam int TAIL_CYCLES  = 32;
  localparam int WATCHDOG_NS  = 10_000_000;

  // A byte that is not a known packet id.
  localparam logic [7:0] ID_UNKNOWN = 8'h00;

  localparam logic [7:0] KNOWN_IDS [8] = '{ID_BUMPER, ID_WALL, ID_CHARGING, ID_CHARGE,
                                           ID_CAPACITY, ID_WALL_SIG, ID_RIGHT, ID_LEFT};

  // Result fields in the order of out_tdata, highest bits first.
  typedef struct packed {
    logic [15:0] left_speed;
    logic [15:0] right_speed;
    logic [15:0] wall_signal;
    logic [6:0]  charge_percent;
    logic [15:0] battery_capacity;
    logic [15:0] battery_charge;
    logic [7:0]  charge_mode;
    logic        wall_seen;
    logic [7:0]  bumper_bits;
  } frame_fields_t;

  typedef struct packed {
    logic          frame_ok;
    frame_fields_t f;
  } frame_report_t;

  // One row of the directed table: the byte and, where typed in, its report.
  typedef struct packed {
    logic [7:0]    data;
    logic          typed;
    frame_report_t rep;
  } stim_row_t;

  typedef enum logic [2:0] {
    WAIT_HDR, GET_LEN, GET_ID, GET_HI, GET_LO, SKIP_REST, CHK_GOOD, CHK_BAD
  } parse_phase_t;

  localparam frame_fields_t FULL_FIELDS = {16'h8000, 16'h7FFF, 16'h8000, 7'd100, 16'h0001,
                                           16'hFFFF, 8'h00, 1'b1, 8'hFF};
  localparam frame_report_t NO_REPORT  = '0;
  localparam frame_report_t EMPTY_GOOD = {1'b1, 104'd0};
  localparam frame_report_t FULL_GOOD  = {1'b1, FULL_FIELDS};
  localparam frame_report_t FULL_BAD   = {1'b0, FULL_FIELDS};

  localparam int DIR_ROWS = 42;

  // Directed stream: a stray byte, an empty frame, a frame with every packet at its
  // extremes, an unknown id, a bad checksum, then a frame whose data holds the
  // header byte and repeats the bumper packet.
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    {8'hFF, 1'b0, NO_REPORT},
    {HDR_BYTE, 1'b0, NO_REPORT}, {8'h00, 1'b0, NO_REPORT}, {8'hED, 1'b1, EMPTY_GOOD},
    {HDR_BYTE, 1'b0, NO_REPORT}, {8'h15, 1'b0, NO_REPORT},
    {ID_BUMPER, 1'b0, NO_REPORT}, {8'hFF, 1'b0, NO_REPORT},
    {ID_WALL, 1'b0, NO_REPORT}, {8'hFF, 1'b0, NO_REPORT},
    {ID_CHARGING, 1'b0, NO_REPORT}, {8'h00, 1'b0, NO_REPORT},
    {ID_CHARGE, 1'b0, NO_REPORT}, {8'hFF, 1'b0, NO_REPORT}, {8'hFF, 1'b0, NO_REPORT},
    {ID_CAPACITY, 1'b0, NO_REPORT}, {8'h00, 1'b0, NO_REPORT}, {8'h01, 1'b0, NO_REPORT},
    {ID_WALL_SIG, 1'b0, NO_REPORT}, {8'h80, 1'b0, NO_REPORT}, {8'h00, 1'b0, NO_REPORT},
    {ID_RIGHT, 1'b0, NO_REPORT}, {8'h7F, 1'b0, NO_REPORT}, {8'hFF, 1'b0, NO_REPORT},
    {ID_LEFT, 1'b0, NO_REPORT}, {8'h80, 1'b0, NO_REPORT}, {8'h00, 1'b0, NO_REPORT},
    {8'h98, 1'b1, FULL_GOOD},
    {HDR_BYTE, 1'b0, NO_REPORT}, {8'h01, 1'b0, NO_REPORT}, {ID_UNKNOWN, 1'b0, NO_REPORT},
    {8'hEC, 1'b1, FULL_BAD},
    {HDR_BYTE, 1'b0, NO_REPORT}, {8'h00, 1'b0, NO_REPORT}, {8'h00, 1'b1, FULL_BAD},
    {HDR_BYTE, 1'b0, NO_REPORT}, {8'h04, 1'b0, NO_REPORT},
    {ID_BUMPER, 1'b0, NO_REPORT}, {HDR_BYTE, 1'b0, NO_REPORT},
    {ID_BUMPER, 1'b0, NO_REPORT}, {8'h55, 1'b0, NO_REPORT},
    {8'h73, 1'b0, NO_REPORT}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // Parser state as the predictor sees it.
  parse_phase_t  ph;
  logic [7:0]    run_sum;
  logic [7:0]    bytes_to_go;
  logic [7:0]    cur_id;
  logic [7:0]    hi_hold;
  frame_fields_t staged;
  frame_fields_t committed;

  frame_report_t pending_reports [$];
  logic [7:0]    frame_q [$];
  bit            steady;
  int            fail_count;
  int            results_seen;
  int            good_frames;
  int            random_frames;

  sensor_stream_frame_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Number of data bytes behind a packet id, zero when the id is unknown.
  function automatic logic [1:0] id_data_len(input logic [7:0] id);
    case (id)
      ID_BUMPER, ID_WALL, ID_CHARGING: return 2'd1;
      ID_CHARGE, ID_CAPACITY, ID_WALL_SIG, ID_RIGHT, ID_LEFT: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  // Writes one packet value into the staged copy of the fields.
  function automatic void store_field(input logic [7:0] id, input logic [15:0] v);
    case (id)
      ID_BUMPER:   staged.bumper_bits = v[7:0];
      ID_WALL:     staged.wall_seen = v[0];
      ID_CHARGING: staged.charge_mode = v[7:0];
      ID_CHARGE:   staged.battery_charge = v;
      ID_CAPACITY: staged.battery_capacity = v;
      ID_WALL_SIG: staged.wall_signal = v;
      ID_RIGHT:    staged.right_speed = v;
      ID_LEFT:     staged.left_speed = v;
      default: ;
    endcase
  endfunction

  // Advances the predicted parser by one byte; a checksum byte yields a report.
  task automatic parse_byte(input logic [7:0] b, output bit done, output frame_report_t rep);
    logic [1:0]  need;
    logic [7:0]  total;
    int unsigned pct;
    done = 1'b0;
    rep = NO_REPORT;
    case (ph)
      WAIT_HDR: begin
        if (b == HDR_BYTE) begin
          run_sum = b;
          staged = committed;
          ph = GET_LEN;
        end
      end
      GET_LEN: begin
        run_sum = run_sum + b;
        bytes_to_go = b;
        ph = (b == 8'd0) ? CHK_GOOD : GET_ID;
      end
      GET_ID: begin
        run_sum = run_sum + b;
        bytes_to_go = bytes_to_go - 8'd1;
        cur_id = b;
        need = id_data_len(b);
        if (need == 2'd0 || need > bytes_to_go)
          ph = (bytes_to_go != 8'd0) ? SKIP_REST : CHK_BAD;
        else
          ph = GET_HI;
      end
      GET_HI: begin
        run_sum = run_sum + b;
        bytes_to_go = bytes_to_go - 8'd1;
        if (id_data_len(cur_id) == 2'd1) begin
          store_field(cur_id, {8'h00, b});
          ph = (bytes_to_go != 8'd0) ? GET_ID : CHK_GOOD;
        end else begin
          hi_hold = b;
          ph = GET_LO;
        end
      end
      GET_LO: begin
        run_sum = run_sum + b;
        bytes_to_go = bytes_to_go - 8'd1;
        store_field(cur_id, {hi_hold, b});
        ph = (bytes_to_go != 8'd0) ? GET_ID : CHK_GOOD;
      end
      SKIP_REST: begin
        run_sum = run_sum + b;
        bytes_to_go = bytes_to_go - 8'd1;
        if (bytes_to_go == 8'd0) ph = CHK_BAD;
      end
      default: begin
        // Checksum byte: commit only a clean frame whose byte sum wraps to zero.
        total = run_sum + b;
        rep.frame_ok = (ph == CHK_GOOD) && (total == 8'd0);
        if (rep.frame_ok) begin
          committed = staged;
          pct = 0;
          if (committed.battery_capacity != 16'd0) begin
            pct = (32'(committed.battery_charge) * 100) / committed.battery_capacity;
            if (pct > 100) pct = 100;
          end
          committed.charge_percent = pct[6:0];
        end
        rep.f = committed;
        done = 1'b1;
        ph = WAIT_HDR;
        run_sum = 8'd0;
        bytes_to_go = 8'd0;
      end
    endcase
  endtask

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Random byte with a bias towards the extremes.
  function automatic logic [7:0] pick_byte();
    logic [7:0] edges [4];
    edges = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 3)];
    return 8'($urandom);
  endfunction

  // Offers one item after a random idle and predicts its effect once it is taken.
  // Returns at the falling edge after acceptance, with in_tvalid still high.
  task automatic send_byte(input logic [7:0] b, input bit use_row,
                           input frame_report_t row_rep);
    int            gap;
    bit            done;
    frame_report_t rep;
    gap = idle_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(b, done, rep);
    if (done) pending_reports.push_back(use_row ? row_rep : rep);
    @(negedge clk);
  endtask

  // Stops offering items until every predicted report has been seen.
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_reports.size() != 0);
  endtask

  // Builds one random frame into frame_q, possibly after stray bytes.
  task automatic build_frame(output int noise_n);
    logic [7:0] body [$];
    logic [7:0] id;
    logic [7:0] chk;
    int         kind;
    bit         good_chk;
    frame_q.delete();
    noise_n = 0;
    good_chk = 1'b1;
    kind = $urandom_range(0, 99);
    // Stray bytes ahead of the header are dropped by the parser.
    if (kind >= 90 && kind < 96) begin
      noise_n = $urandom_range(1, 4);
      repeat (noise_n) begin
        do id = 8'($urandom); while (id == HDR_BYTE);
        frame_q.push_back(id);
      end
    end
    // Well-formed packets, repeats allowed.
    if (kind < 96) begin
      repeat ($urandom_range(0, 6)) begin
        id = KNOWN_IDS[$urandom_range(0, 7)];
        body.push_back(id);
        body.push_back(pick_byte());
        if (id_data_len(id) == 2'd2) body.push_back(pick_byte());
      end
    end
    if (kind < 70) begin
      good_chk = ($urandom_range(0, 9) != 0);
    end else if (kind < 80) begin
      // Unknown id followed by a few bytes that are skipped.
      do id = 8'($urandom); while (id_data_len(id) != 2'd0);
      body.push_back(id);
      repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
    end else if (kind < 90) begin
      // Last packet cut short by the length byte.
      id = KNOWN_IDS[$urandom_range(0, 7)];
      body.push_back(id);
      if (id_data_len(id) == 2'd2 && $urandom_range(0, 1) == 1) body.push_back(pick_byte());
    end else if (kind >= 96) begin
      // Arbitrary content, now and then long enough to set the top length bit.
      repeat ((kind == 99) ? $urandom_range(128, 200) : $urandom_range(1, 12))
        body.push_back(8'($urandom));
    end
    chk = HDR_BYTE + 8'(body.size());
    foreach (body[i]) chk = chk + body[i];
    chk = 8'h00 - chk;
    if (!good_chk) chk = chk + 8'($urandom_range(1, 255));
    frame_q.push_back(HDR_BYTE);
    frame_q.push_back(8'(body.size()));
    foreach (body[i]) frame_q.push_back(body[i]);
    frame_q.push_back(chk);
  endtask

  task automatic field_check(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Result side: ready drops for random stretches.
  initial begin
    int hold;
    out_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        hold = idle_length();
        out_tready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  // Each accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    frame_report_t got;
    frame_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.frame_ok = out_tuser;
      got.f = out_tdata;
      if (pending_reports.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        results_seen++;
        if (want.frame_ok) good_frames++;
        field_check("frame_ok", 16'(want.frame_ok), 16'(got.frame_ok));
        field_check("bumper_bits", 16'(want.f.bumper_bits), 16'(got.f.bumper_bits));
        field_check("wall_seen", 16'(want.f.wall_seen), 16'(got.f.wall_seen));
        field_check("charge_mode", 16'(want.f.charge_mode), 16'(got.f.charge_mode));
        field_check("battery_charge", want.f.battery_charge, got.f.battery_charge);
        field_check("battery_capacity", want.f.battery_capacity, got.f.battery_capacity);
        field_check("charge_percent", 16'(want.f.charge_percent),
                    16'(got.f.charge_percent));
        field_check("wall_signal", want.f.wall_signal, got.f.wall_signal);
        field_check("right_speed", want.f.right_speed, got.f.right_speed);
        field_check("left_speed", want.f.left_speed, got.f.left_speed);
      end
    end
  end

  // Stimulus: reset, the directed table, then random frames.
  initial begin
    int items_sent;
    int noise_n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    steady = 1'b0;
    fail_count = 0;
    results_seen = 0;
    good_frames = 0;
    random_frames = 0;
    items_sent = 0;
    ph = WAIT_HDR;
    run_sum = 8'd0;
    bytes_to_go = 8'd0;
    cur_id = 8'd0;
    hi_hold = 8'd0;
    staged = '0;
    committed = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIR_ROWS; k++)
      send_byte(DIR_TAB[k].data, DIR_TAB[k].typed, DIR_TAB[k].rep);
    hold_until_drained();

    while (items_sent < RANDOM_ITEMS) begin
      build_frame(noise_n);
      steady = ($urandom_range(0, 3) == 0);
      foreach (frame_q[i]) send_byte(frame_q[i], 1'b0, NO_REPORT);
      items_sent += frame_q.size() - noise_n;
      random_frames++;
      if ($urandom_range(0, 24) == 0) hold_until_drained();
    end
    steady = 1'b0;
    hold_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d directed and %0d random frame items in %0d random frames.",
             DIR_ROWS, items_sent, random_frames);
    $display("Checked %0d results: %0d good frames, %0d rejected.",
             results_seen, good_frames, results_seen - good_frames);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(WATCHDOG_NS);
    $display("%0t: timeout with %0d results outstanding", $time, pending_reports.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
